FILE: sv/dld_pkg.sv
// Shared types and helpers for the dual-lane binary64 divider.
// Used by every stage module and the top level; no dependencies.
package dld_pkg;

    localparam int unsigned FracW   = 52;
    localparam int unsigned ExpW    = 11;
    localparam int unsigned EW      = 13;   // internal signed exponent
    localparam int unsigned QW      = 56;   // 53 significant + 3 extra bits
    localparam int unsigned BitsPerStep = 2;
    localparam int unsigned NumSteps    = QW / BitsPerStep;

    localparam logic [63:0]   QNAN    = 64'h7FF8_0000_0000_0000;
    localparam logic [ExpW-1:0] EXP_MAX = 11'h7FF;
    localparam logic signed [EW-1:0] EXP_BIAS = 13'sd1023;
    localparam logic signed [EW-1:0] EXP_TOP  = 13'sd2047;

    typedef struct packed {
        logic                  spec;   // result already decided
        logic [63:0]           res;    // decided result bits
        logic                  sign;
        logic signed [EW-1:0]  e;
        logic [5:0]            lza;
        logic [5:0]            lzb;
        logic [54:0]           rem;    // partial remainder (dividend at entry)
        logic [52:0]           mb;     // divisor significand
        logic [QW-1:0]         q;
        logic                  stk;
    } t_lane;

    typedef struct packed {
        t_lane lo;
        t_lane hi;
        logic  last;
    } t_item;

    // leading zeros of a 53-bit significand (53 when zero)
    function automatic logic [5:0] lzc53(input logic [52:0] m);
        logic [5:0] n;
        n = 6'd53;
        for (int i = 0; i < 53; i++) begin
            if (m[i]) n = 6'(52 - i);
        end
        return n;
    endfunction

endpackage

FILE: sv/dual_lane_double_divider_top.sv
// 32 register stages lie between input and output transaction: unpack,
// normalize, 28 restoring-division stages of two bits, align, round.
// Throughput: one 128-bit word per cycle unless m_axis_tready stalls; each
// stage register advances when its successor is free, so bubbles collapse
// and stalls lose nothing.
// Reset: synchronous active-low i_rst_n clears all stage valid bits.
// Depends on dld_pkg and the dld_* stage modules.
module dual_lane_double_divider_top import dld_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // dividend_low[63:0], dividend_high[127:64], divisor_low[191:128],
    // divisor_high[255:192]
    input  logic [255:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // quotient_low[63:0], quotient_high[127:64]
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    logic  vld [NumSteps+3];
    logic  rdy [NumSteps+3];
    t_item dat [NumSteps+3];

    dld_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_axis_tvalid),
        .i_a_lo  (s_axis_tdata[63:0]),
        .i_a_hi  (s_axis_tdata[127:64]),
        .i_b_lo  (s_axis_tdata[191:128]),
        .i_b_hi  (s_axis_tdata[255:192]),
        .i_last  (s_axis_tlast),
        .o_rdy   (s_axis_tready),
        .o_vld   (vld[0]),
        .o_dat   (dat[0]),
        .i_rdy   (rdy[0])
    );

    dld_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld[0]),
        .i_dat   (dat[0]),
        .o_rdy   (rdy[0]),
        .o_vld   (vld[1]),
        .o_dat   (dat[1]),
        .i_rdy   (rdy[1])
    );

    for (genvar g = 0; g < NumSteps; g++) begin : g_div
        dld_divstep u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (vld[g+1]),
            .i_dat   (dat[g+1]),
            .o_rdy   (rdy[g+1]),
            .o_vld   (vld[g+2]),
            .o_dat   (dat[g+2]),
            .i_rdy   (rdy[g+2])
        );
    end

    dld_align u_align (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld[NumSteps+1]),
        .i_dat   (dat[NumSteps+1]),
        .o_rdy   (rdy[NumSteps+1]),
        .o_vld   (vld[NumSteps+2]),
        .o_dat   (dat[NumSteps+2]),
        .i_rdy   (rdy[NumSteps+2])
    );

    dld_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld[NumSteps+2]),
        .i_dat   (dat[NumSteps+2]),
        .o_rdy   (rdy[NumSteps+2]),
        .o_vld   (m_axis_tvalid),
        .o_quot  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .i_rdy   (m_axis_tready)
    );
endmodule

FILE: sv/dld_unpack.sv
// Stage 1: operand classification, special results and leading-zero count.
// Depends on dld_pkg.
module dld_unpack import dld_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [63:0] i_a_lo,
    input  logic [63:0] i_a_hi,
    input  logic [63:0] i_b_lo,
    input  logic [63:0] i_b_hi,
    input  logic        i_last,
    output logic        o_rdy,
    output logic        o_vld,
    output t_item       o_dat,
    input  logic        i_rdy
);
    logic  r_vld;
    t_item r_dat;
    t_item n_dat;

    function automatic t_lane unpack(input logic [63:0] a, input logic [63:0] b);
        t_lane l;
        logic [ExpW-1:0] ea, eb;
        logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, s;
        logic [63:0] inf_bits;
        ea = a[62:52];
        eb = b[62:52];
        s  = a[63] ^ b[63];
        a_nan  = (ea == EXP_MAX) && (a[51:0] != '0);
        b_nan  = (eb == EXP_MAX) && (b[51:0] != '0);
        a_inf  = (ea == EXP_MAX) && (a[51:0] == '0);
        b_inf  = (eb == EXP_MAX) && (b[51:0] == '0);
        a_zero = (ea == '0) && (a[51:0] == '0);
        b_zero = (eb == '0) && (b[51:0] == '0);
        inf_bits = {s, EXP_MAX, 52'd0};
        l = '0;
        l.sign = s;
        l.spec = 1'b1;
        if (a_nan || b_nan)  l.res = QNAN;
        else if (a_inf)      l.res = b_inf ? QNAN : inf_bits;
        else if (b_inf)      l.res = {s, 63'd0};
        else if (a_zero)     l.res = b_zero ? QNAN : {s, 63'd0};
        else if (b_zero)     l.res = inf_bits;
        else                 l.spec = 1'b0;
        l.rem = {2'b00, (ea != '0), a[51:0]};
        l.mb  = {(eb != '0), b[51:0]};
        l.lza = (ea != '0) ? 6'd0 : lzc53({1'b0, a[51:0]});
        l.lzb = (eb != '0) ? 6'd0 : lzc53({1'b0, b[51:0]});
        l.e = EW'(signed'({2'b00, (ea == '0) ? 11'd1 : ea}))
            - EW'(signed'({2'b00, (eb == '0) ? 11'd1 : eb})) + EXP_BIAS;
        return l;
    endfunction

    always_comb begin
        n_dat.lo   = unpack(i_a_lo, i_b_lo);
        n_dat.hi   = unpack(i_a_hi, i_b_hi);
        n_dat.last = i_last;
    end

    assign o_rdy = !r_vld || i_rdy;
    assign o_vld = r_vld;
    assign o_dat = r_dat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (o_rdy && i_vld) begin
            r_dat <= n_dat;
        end
    end
endmodule

FILE: sv/dld_norm.sv
// Stage 2: significand normalization and dividend pre-alignment.
// Depends on dld_pkg.
module dld_norm import dld_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_item i_dat,
    output logic  o_rdy,
    output logic  o_vld,
    output t_item o_dat,
    input  logic  i_rdy
);
    logic  r_vld;
    t_item r_dat;
    t_item n_dat;

    function automatic t_lane norm(input t_lane l);
        t_lane r;
        logic [52:0] ma, mb;
        r  = l;
        ma = l.rem[52:0] << l.lza;
        mb = l.mb << l.lzb;
        r.e = l.e - EW'(signed'({1'b0, l.lza})) + EW'(signed'({1'b0, l.lzb}));
        r.mb = mb;
        r.q  = '0;
        if (ma < mb) begin
            r.rem = {1'b0, ma, 1'b0};
            r.e   = r.e - EW'(1);
        end else begin
            r.rem = {2'b00, ma};
        end
        return r;
    endfunction

    always_comb begin
        n_dat.lo   = norm(i_dat.lo);
        n_dat.hi   = norm(i_dat.hi);
        n_dat.last = i_dat.last;
    end

    assign o_rdy = !r_vld || i_rdy;
    assign o_vld = r_vld;
    assign o_dat = r_dat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (o_rdy && i_vld) begin
            r_dat <= n_dat;
        end
    end
endmodule

FILE: sv/dld_divstep.sv
// One restoring-division stage: BitsPerStep quotient bits per lane.
// Depends on dld_pkg.
module dld_divstep import dld_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_item i_dat,
    output logic  o_rdy,
    output logic  o_vld,
    output t_item o_dat,
    input  logic  i_rdy
);
    logic  r_vld;
    t_item r_dat;
    t_item n_dat;

    function automatic t_lane step(input t_lane l);
        t_lane r;
        r = l;
        for (int k = 0; k < BitsPerStep; k++) begin
            r.q = r.q << 1;
            if (r.rem >= {2'b00, r.mb}) begin
                r.rem  = r.rem - {2'b00, r.mb};
                r.q[0] = 1'b1;
            end
            r.rem = r.rem << 1;
        end
        return r;
    endfunction

    always_comb begin
        n_dat.lo   = step(i_dat.lo);
        n_dat.hi   = step(i_dat.hi);
        n_dat.last = i_dat.last;
    end

    assign o_rdy = !r_vld || i_rdy;
    assign o_vld = r_vld;
    assign o_dat = r_dat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (o_rdy && i_vld) begin
            r_dat <= n_dat;
        end
    end
endmodule

FILE: sv/dld_align.sv
// Post-divide stage: overflow detection and denormal right shift with sticky.
// Depends on dld_pkg.
module dld_align import dld_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_item i_dat,
    output logic  o_rdy,
    output logic  o_vld,
    output t_item o_dat,
    input  logic  i_rdy
);
    logic  r_vld;
    t_item r_dat;
    t_item n_dat;

    function automatic t_lane align(input t_lane l);
        t_lane r;
        logic signed [EW-1:0] sh_full;
        logic [5:0] sh;
        logic lost;
        r = l;
        r.stk = (l.rem != '0);
        sh_full = EW'(1) - l.e;
        sh = sh_full[5:0];
        lost = 1'b0;
        if (!l.spec) begin
            if (l.e >= EXP_TOP) begin
                r.spec = 1'b1;
                r.res  = {l.sign, EXP_MAX, 52'd0};
            end else if (l.e <= EW'(0)) begin
                if (sh_full >= EW'(60)) begin
                    r.stk = r.stk || (l.q != '0);
                    r.q   = '0;
                end else begin
                    for (int i = 0; i < QW; i++) begin
                        if (6'(i) < sh) lost = lost | l.q[i];
                    end
                    r.stk = r.stk || lost;
                    r.q   = l.q >> sh;
                end
            end
        end
        return r;
    endfunction

    always_comb begin
        n_dat.lo   = align(i_dat.lo);
        n_dat.hi   = align(i_dat.hi);
        n_dat.last = i_dat.last;
    end

    assign o_rdy = !r_vld || i_rdy;
    assign o_vld = r_vld;
    assign o_dat = r_dat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (o_rdy && i_vld) begin
            r_dat <= n_dat;
        end
    end
endmodule

FILE: sv/dld_round.sv
// Final stage: round to nearest even and pack binary64; holds the output register.
// Depends on dld_pkg.
module dld_round import dld_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_vld,
    input  t_item        i_dat,
    output logic         o_rdy,
    output logic         o_vld,
    output logic [127:0] o_quot,
    output logic         o_last,
    input  logic         i_rdy
);
    logic         r_vld;
    logic [127:0] r_quot;
    logic         r_last;
    logic [127:0] n_quot;

    function automatic logic [63:0] pack(input t_lane l);
        logic [52:0] mant;
        logic [2:0]  low;
        logic        up;
        logic [53:0] m2;
        logic signed [EW-1:0] e2;
        logic [63:0] r;
        mant = l.q[55:3];
        low  = l.q[2:0];
        up   = low[2] && ((low[1:0] != '0) || l.stk || mant[0]);
        m2   = {1'b0, mant} + 54'(up);
        e2   = l.e;
        if (l.spec) begin
            r = l.res;
        end else if (l.e <= EW'(0)) begin
            r = {l.sign, 10'd0, m2[52:0]};
        end else if (m2[53]) begin
            e2 = l.e + EW'(1);
            if (e2 >= EXP_TOP) r = {l.sign, EXP_MAX, 52'd0};
            else               r = {l.sign, e2[10:0], m2[52:1]};
        end else begin
            r = {l.sign, e2[10:0], m2[51:0]};
        end
        return r;
    endfunction

    assign n_quot = {pack(i_dat.hi), pack(i_dat.lo)};
    assign o_rdy  = !r_vld || i_rdy;
    assign o_vld  = r_vld;
    assign o_quot = r_quot;
    assign o_last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (o_rdy && i_vld) begin
            r_quot <= n_quot;
            r_last <= i_dat.last;
        end
    end
endmodule

FILE: sv/dld_checker.sv
// Port-level checker for the dual-lane divider, bound to the top level.
// Depends only on the top-level ports.
module dld_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    // pipeline comes out of reset empty
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // with the output register free, nothing upstream may block input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while output empty");

    // with i_rst_n low both now and in $past, the cycle after shows no result
    // and s_axis_tready high
    a_no_spurious: assert property (@(posedge i_clk)
        !$past(i_rst_n) && !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not flushed by reset");
endmodule

bind dual_lane_double_divider_top dld_checker u_dld_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: verif/testbench.sv
// Self-checking bench for dual_lane_double_divider_top: two binary64 quotients per word.
// Predicts each quotient with a bit-exact integer divider; depends only on the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] q_lo;
        logic [63:0] q_hi;
        logic        last;
    } quot_t;

    // binary64 division, round to nearest even, canonical NaN
    function automatic logic [63:0] div_binary64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] sgn, inf_bits, ma, mb, rem, q, mant, low;
        int ea, eb, ex, sh;
        bit a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, stk, up;
        sgn = (a ^ b) & 64'h8000_0000_0000_0000;
        inf_bits = sgn | 64'h7FF0_0000_0000_0000;
        a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 0);
        b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 0);
        a_inf = (a[62:52] == 11'h7FF) && (a[51:0] == 0);
        b_inf = (b[62:52] == 11'h7FF) && (b[51:0] == 0);
        a_zero = (a[62:0] == 0);
        b_zero = (b[62:0] == 0);
        if (a_nan || b_nan) return 64'h7FF8_0000_0000_0000;
        if (a_inf) return b_inf ? 64'h7FF8_0000_0000_0000 : inf_bits;
        if (b_inf) return sgn;
        if (a_zero) return b_zero ? 64'h7FF8_0000_0000_0000 : sgn;
        if (b_zero) return inf_bits;
        ma = {12'd0, a[51:0]};
        ea = a[62:52];
        if (ea == 0) begin
            ea = 1;
            while (!ma[52]) begin
                ma = ma << 1;
                ea--;
            end
        end else ma[52] = 1'b1;
        mb = {12'd0, b[51:0]};
        eb = b[62:52];
        if (eb == 0) begin
            eb = 1;
            while (!mb[52]) begin
                mb = mb << 1;
                eb--;
            end
        end else mb[52] = 1'b1;
        ex = ea - eb + 1023;
        if (ma < mb) begin
            ma = ma << 1;
            ex--;
        end
        rem = ma;
        q = 0;
        for (int i = 0; i < 56; i++) begin
            q = q << 1;
            if (rem >= mb) begin
                rem = rem - mb;
                q[0] = 1'b1;
            end
            rem = rem << 1;
        end
        stk = (rem != 0);
        if (ex >= 2047) return inf_bits;
        if (ex <= 0) begin
            sh = 1 - ex;
            if (sh >= 60) begin
                stk = stk || (q != 0);
                q = 0;
            end else begin
                stk = stk || ((q & ((64'd1 << sh) - 1)) != 0);
                q = q >> sh;
            end
        end
        mant = q >> 3;
        low = q & 7;
        up = low[2] && ((low[1:0] != 0) || stk || mant[0]);
        mant = mant + up;
        if (ex <= 0) return sgn | mant;
        if (mant == 64'h0020_0000_0000_0000) begin
            mant = mant >> 1;
            ex++;
            if (ex >= 2047) return inf_bits;
        end
        return sgn | (64'(ex) << 52) | (mant & 64'h000F_FFFF_FFFF_FFFF);
    endfunction

    class quotient_scoreboard;
        quot_t pending[$];
        int    errors;

        function void note_word(input logic [255:0] d, input logic lst);
            quot_t r;
            r.q_lo = div_binary64(d[63:0], d[191:128]);
            r.q_hi = div_binary64(d[127:64], d[255:192]);
            r.last = lst;
            pending.push_back(r);
        endfunction

        function void check_word(input logic [127:0] d, input logic lst);
            quot_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h last %b", d, lst);
                return;
            end
            e = pending.pop_front();
            if (e.q_lo !== d[63:0] || e.q_hi !== d[127:64] || e.last !== lst) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp %h %h %b, got %h %h %b",
                        e.q_lo, e.q_hi, e.last, d[63:0], d[127:64], lst);
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;  // dividend_low, dividend_high, divisor_low, divisor_high
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;  // quotient_low, quotient_high
    logic         m_axis_tlast;

    quotient_scoreboard sb;
    bit drained;
    bit hold_off;
    int idle_cycles;

    dual_lane_double_divider_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // operand with a bias toward special classes and nearby exponents
    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        v = rand64();
        case ($urandom_range(0, 11))
            0: v[62:52] = 11'h7FF;
            1: v[62:52] = 11'h000;
            2: v[62:0] = 63'd0;
            3: v[62:52] = 11'(($urandom_range(0, 1)) ? $urandom_range(1, 40)
                                                       : $urandom_range(2000, 2046));
            4: v[51:0] = 52'd0;
            default: v[62:52] = 11'($urandom_range(900, 1150));
        endcase
        return v;
    endfunction

    // one word; tvalid stays high across back-to-back calls
    task automatic send_word(input logic [63:0] a0, input logic [63:0] a1,
                             input logic [63:0] b0, input logic [63:0] b1,
                             input logic lst);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b1, b0, a1, a0};
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic run_directed();
        logic [63:0] ops[14];
        ops = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000,
                64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000, 64'h4008_0000_0000_0000,
                64'h3FE0_0000_0000_0000, 64'h7FF0_0000_0000_0001};
        for (int i = 0; i < 14; i++)
            send_word(ops[i], ops[13 - i], ops[(i + 3) % 14], ops[(i + 7) % 14], i[0]);
        // overflow, underflow into subnormals, round-up to smallest normal
        send_word(64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
                  64'h3FE0_0000_0000_0000, 64'h4340_0000_0000_0000, 1'b0);
        send_word(64'h000F_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000,
                  64'h3FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 1'b1);
        send_word(64'h3FF0_0000_0000_0001, 64'hBFF0_0000_0000_0000,
                  64'h4008_0000_0000_0000, 64'h0000_0000_0000_0003, 1'b0);
        send_word(64'h0000_0000_0000_0003, 64'h001F_FFFF_FFFF_FFFF,
                  64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b1);
        idle_gap(1);
    endtask

    // input and output monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tdata, s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: own stall pattern, plus one long hold-off
    initial begin
        int phase;
        phase = 0;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (150) @(posedge i_clk);
                hold_off = 1'b0;
            end
            phase++;
            if ((phase / 200) % 3 == 0) m_axis_tready <= 1'b1;
            else m_axis_tready <= ((phase % 7) < 4) || ($urandom_range(0, 3) == 0);
            @(posedge i_clk);
        end
    end

    initial begin
        logic [63:0] a0, a1, b0, b1;
        int burst;
        sb = new();
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        hold_off = 1'b1;
        for (int n = 0; n < 800; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) begin
                a0 = pick_operand();
                a1 = ($urandom_range(0, 3) == 0) ? rand64() : pick_operand();
                b0 = pick_operand();
                b1 = ($urandom_range(0, 3) == 0) ? rand64() : pick_operand();
                send_word(a0, a1, b0, b1, 1'($urandom_range(0, 1)));
                n++;
            end
            if (!drained && n > 400) begin
                // drain completely mid-run
                drained = 1'b1;
                idle_gap(1);
                while (sb.pending.size() != 0) @(posedge i_clk);
            end else if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
        end
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: filelist.f
sv/dld_pkg.sv
sv/dld_unpack.sv
sv/dld_norm.sv
sv/dld_divstep.sv
sv/dld_align.sv
sv/dld_round.sv
sv/dual_lane_double_divider_top.sv
sv/dld_checker.sv
verif/testbench.sv
